// ===== src/etb_pkg.sv =====
// Package for the event timer bank: opcodes, slot modes, transaction
// payload types and the command/status types between controller and datapath.
// No dependencies.
package etb_pkg;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_DISPATCH = 3'd1;
    localparam logic [2:0] OP_START    = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_QUERY    = 3'd4;

    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_COUNTING = 2'd1;
    localparam logic [1:0] MODE_DUE      = 2'd2;
    localparam logic [1:0] MODE_FINISHED = 2'd3;

    localparam int MAX_FIRED = 8;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  timer_id;
        logic        periodic;
        logic [15:0] period;
    } req_t;

    typedef struct packed {
        logic       fired_valid;
        logic [2:0] fired_index;
        logic [1:0] mode_read;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        periodic;
        logic [15:0] period;
        logic [15:0] count;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic start_wr;
        logic prime_rd;
        logic id_rd;
        logic eval;
        logic stop_wr;
        logic flush;
        logic query_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_opcode;
        logic       req_id_ok;
        logic       dispatch;
        logic       id_ok;
        logic       out_free;
        logic       due_hit;
        logic       pend_valid;
        logic       last_slot;
        logic       cap_hit;
    } sts_t;

endpackage

// ===== src/etb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module etb_ram #(
    parameter int WIDTH  = 35,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/etb_dp.sv =====
// Datapath of the event timer bank: slot RAM, per-slot valid flags, scan
// counter, pending fired slot and the result register.
// Depends on etb_pkg and etb_ram.
module etb_dp #(
    parameter int NUM_TIMERS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  etb_pkg::req_t req,
    input  etb_pkg::cmd_t cmd,
    input  logic          rsp_stall,
    output etb_pkg::sts_t sts,
    output etb_pkg::rsp_t rsp,
    output logic          rsp_valid
);

    import etb_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int FW = $clog2(MAX_FIRED);

    logic [2:0]            op_reg;
    logic [7:0]            id_reg;
    logic [CW-1:0]         idx_reg;
    logic [FW-1:0]         found_reg;
    logic                  pend_valid_reg;
    logic [AW-1:0]         pend_idx_reg;
    logic [NUM_TIMERS-1:0] valid_reg;
    logic                  rvalid_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic          we;
    logic [AW-1:0] waddr;
    slot_t         wdata;
    logic          re;
    logic [AW-1:0] raddr;
    slot_t         rdata;
    slot_t         rslot;
    slot_t         upd;
    logic [CW-1:0] idx_inc;
    logic          push;
    rsp_t          item;
    logic          out_free;

    etb_ram #(
        .WIDTH (35),
        .DEPTH (NUM_TIMERS),
        .ADDR_W(AW)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rslot    = rvalid_reg ? rdata : '0;
    assign idx_inc  = idx_reg + 1'b1;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign sts.req_opcode = req.opcode;
    assign sts.req_id_ok  = req.timer_id < 8'(NUM_TIMERS);
    assign sts.dispatch   = op_reg == OP_DISPATCH;
    assign sts.id_ok      = id_reg < 8'(NUM_TIMERS);
    assign sts.out_free   = out_free;
    assign sts.due_hit    = (op_reg == OP_DISPATCH) && (rslot.mode == MODE_DUE);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.last_slot  = idx_reg == CW'(NUM_TIMERS - 1);
    assign sts.cap_hit    = found_reg == FW'(MAX_FIRED - 1);

    always_comb
    begin
        upd = rslot;
        if (op_reg != OP_DISPATCH)
        begin
            if (rslot.mode == MODE_COUNTING)
            begin
                upd.count = rslot.count + 16'd1;
                if (upd.count == rslot.period)
                begin
                    upd.mode = MODE_DUE;
                end
            end
        end
        else if (rslot.mode == MODE_DUE)
        begin
            if (rslot.periodic)
            begin
                upd.count = 16'd0;
                upd.mode  = MODE_COUNTING;
            end
            else
            begin
                upd.mode = MODE_FINISHED;
            end
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = upd;
        if (cmd.start_wr)
        begin
            we    = 1'b1;
            waddr = req.timer_id[AW-1:0];
            wdata = '{mode: MODE_COUNTING, periodic: req.periodic,
                      period: req.period, count: 16'd0};
        end
        else if (cmd.eval)
        begin
            we = 1'b1;
        end
        else if (cmd.stop_wr)
        begin
            we         = 1'b1;
            waddr      = id_reg[AW-1:0];
            wdata      = rslot;
            wdata.mode = MODE_DISABLED;
        end
    end

    always_comb
    begin
        re    = 1'b0;
        raddr = idx_reg[AW-1:0];
        if (cmd.prime_rd)
        begin
            re = 1'b1;
        end
        else if (cmd.eval && !sts.last_slot)
        begin
            re    = 1'b1;
            raddr = idx_inc[AW-1:0];
        end
        else if (cmd.id_rd)
        begin
            re    = 1'b1;
            raddr = id_reg[AW-1:0];
        end
    end

    always_comb
    begin
        push = 1'b0;
        item = '0;
        if (cmd.eval && sts.due_hit && pend_valid_reg)
        begin
            push             = 1'b1;
            item.fired_valid = 1'b1;
            item.fired_index = 3'(pend_idx_reg);
        end
        else if (cmd.flush)
        begin
            push             = 1'b1;
            item.fired_valid = pend_valid_reg;
            item.fired_index = 3'(pend_idx_reg);
            item.last        = 1'b1;
        end
        else if (cmd.query_out)
        begin
            push           = 1'b1;
            item.mode_read = sts.id_ok ? rslot.mode : MODE_DISABLED;
            item.last      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_TICK;
            idx_reg        <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
            rvalid_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                op_reg         <= req.opcode;
                idx_reg        <= '0;
                found_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.eval)
            begin
                idx_reg <= idx_inc;
                if (sts.due_hit)
                begin
                    pend_valid_reg <= 1'b1;
                    if (!sts.cap_hit)
                    begin
                        found_reg <= found_reg + 1'b1;
                    end
                end
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
            if (push)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg       <= req.timer_id;
            pend_idx_reg <= '0;
        end
        else if (cmd.eval && sts.due_hit)
        begin
            pend_idx_reg <= idx_reg[AW-1:0];
        end
        if (push)
        begin
            rsp_reg <= item;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== src/etb_ctrl.sv =====
// Controller of the event timer bank: sequences slot scans, stop and query
// accesses and result transactions.
// Depends on etb_pkg.
module etb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  etb_pkg::sts_t sts,
    output etb_pkg::cmd_t cmd,
    output logic          req_stall
);

    import etb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_EVAL,
        S_FLUSH,
        S_STOP_RD,
        S_STOP_WR,
        S_QUERY_RD,
        S_QUERY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   req_stall_reg;
    logic   wait_out;

    assign wait_out = sts.due_hit && sts.pend_valid && !sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept   = 1'b1;
                    cmd.start_wr = (sts.req_opcode == OP_START) && sts.req_id_ok;
                    unique case (sts.req_opcode) inside
                        OP_TICK, OP_DISPATCH: state_next = S_PRIME;
                        OP_STOP:              state_next = sts.req_id_ok ? S_STOP_RD : S_IDLE;
                        OP_QUERY:             state_next = S_QUERY_RD;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_PRIME:
            begin
                cmd.prime_rd = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                if (!wait_out)
                begin
                    cmd.eval = 1'b1;
                    if ((sts.due_hit && sts.cap_hit) || sts.last_slot)
                    begin
                        state_next = sts.dispatch ? S_FLUSH : S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_STOP_RD:
            begin
                cmd.id_rd  = 1'b1;
                state_next = S_STOP_WR;
            end
            S_STOP_WR:
            begin
                cmd.stop_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_QUERY_RD:
            begin
                cmd.id_rd  = sts.id_ok;
                state_next = S_QUERY;
            end
            S_QUERY:
            begin
                if (sts.out_free)
                begin
                    cmd.query_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_stall_reg <= state_next != S_IDLE;
        end
    end

    assign req_stall = req_stall_reg;

endmodule

// ===== src/event_timer_bank.sv =====
// Event timer bank top level: controller plus slot datapath.
// A dispatch waits while the result side stalls. Scan speed is set by the single
// slot RAM port, which visits one slot per cycle during a scan, unless a fired
// slot waits on an occupied result register. Reset is immediate: per-slot valid
// flags make every slot read as disabled, with no clearing pass.
module event_timer_bank #(
    parameter int NUM_TIMERS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  etb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output etb_pkg::rsp_t rsp
);

    import etb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    etb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .sts      (sts),
        .cmd      (cmd),
        .req_stall(req_stall)
    );

    etb_dp #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .rsp_stall(rsp_stall),
        .sts      (sts),
        .rsp      (rsp),
        .rsp_valid(rsp_valid)
    );

    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> sts.out_free)
        else $error("flush with result register occupied");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && sts.due_hit && sts.pend_valid) |-> sts.out_free)
        else $error("pending slot pushed into occupied result register");

    a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> (!cmd.eval && !cmd.flush && !cmd.query_out))
        else $error("request accepted while a scan or result is in progress");

    a_unfired_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.fired_valid) |-> rsp.last)
        else $error("non-fired result not marked last");

endmodule

// ===== tb/etb_checker.sv =====
`timescale 1ns / 100ps
// Checker for the event timer bank: watches the command and response channels,
// keeps its own copy of the slot table and compares every response transaction.
// Depends on etb_pkg for the payload types, opcodes and slot modes.
module etb_checker #(
    parameter int NUM_TIMERS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  etb_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  etb_pkg::rsp_t rsp,
    output int            errors,
    output int            pending,
    output int            checked,
    output int            fired
);
    import etb_pkg::*;

    logic [1:0]  slot_mode     [NUM_TIMERS];
    logic        slot_periodic [NUM_TIMERS];
    logic [15:0] slot_period   [NUM_TIMERS];
    logic [15:0] slot_count    [NUM_TIMERS];
    rsp_t        owed_rsp      [$];

    task automatic advance_table(input req_t c);
        rsp_t batch [MAX_FIRED];
        rsp_t one;
        int   n;
        int   i;
        n = 0;
        one = '0;
        case (c.opcode)
            OP_TICK:
            begin
                for (i = 0; i < NUM_TIMERS; i++)
                begin
                    if (slot_mode[i] == MODE_COUNTING)
                    begin
                        slot_count[i] = slot_count[i] + 16'd1;
                        if (slot_count[i] == slot_period[i])
                            slot_mode[i] = MODE_DUE;
                    end
                end
            end
            OP_DISPATCH:
            begin
                for (i = 0; i < NUM_TIMERS && n < MAX_FIRED; i++)
                begin
                    if (slot_mode[i] == MODE_DUE)
                    begin
                        one = '0;
                        one.fired_valid = 1'b1;
                        one.fired_index = i[2:0];
                        batch[n] = one;
                        n++;
                        if (slot_periodic[i])
                        begin
                            slot_count[i] = '0;
                            slot_mode[i] = MODE_COUNTING;
                        end
                        else
                        begin
                            slot_mode[i] = MODE_FINISHED;
                        end
                    end
                end
                if (n == 0)
                begin
                    one = '0;
                    one.last = 1'b1;
                    owed_rsp.push_back(one);
                end
                else
                begin
                    one = batch[n - 1];
                    one.last = 1'b1;
                    batch[n - 1] = one;
                    for (i = 0; i < n; i++)
                        owed_rsp.push_back(batch[i]);
                end
            end
            OP_START:
            begin
                if (c.timer_id < NUM_TIMERS)
                begin
                    slot_mode[c.timer_id] = MODE_COUNTING;
                    slot_periodic[c.timer_id] = c.periodic;
                    slot_period[c.timer_id] = c.period;
                    slot_count[c.timer_id] = '0;
                end
            end
            OP_STOP:
            begin
                if (c.timer_id < NUM_TIMERS)
                    slot_mode[c.timer_id] = MODE_DISABLED;
            end
            OP_QUERY:
            begin
                one.last = 1'b1;
                if (c.timer_id < NUM_TIMERS)
                    one.mode_read = slot_mode[c.timer_id];
                else
                    one.mode_read = MODE_DISABLED;
                owed_rsp.push_back(one);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_rsp(input rsp_t got);
        rsp_t want;
        if (owed_rsp.size() == 0)
        begin
            $error("response transaction %h with nothing pending", got);
            errors++;
        end
        else
        begin
            want = owed_rsp.pop_front();
            checked++;
            if (want.fired_valid)
                fired++;
            if (got.fired_valid !== want.fired_valid)
            begin
                $error("fired_valid: expected %0d, got %0d", want.fired_valid, got.fired_valid);
                errors++;
            end
            if (got.fired_index !== want.fired_index)
            begin
                $error("fired_index: expected %0d, got %0d", want.fired_index, got.fired_index);
                errors++;
            end
            if (got.mode_read !== want.mode_read)
            begin
                $error("mode_read: expected %0d, got %0d", want.mode_read, got.mode_read);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                slot_mode[i] = MODE_DISABLED;
                slot_periodic[i] = 1'b0;
                slot_period[i] = '0;
                slot_count[i] = '0;
            end
            owed_rsp.delete();
            errors = 0;
            pending = 0;
            checked = 0;
            fired = 0;
        end
        else
        begin
            // predict first, so a response in the same cycle finds its entry
            if (req_valid && !req_stall)
                advance_table(req);
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp);
            pending = owed_rsp.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the event timer bank testbench: clock, reset, command stimulus and
// response back-pressure, with etb_checker beside the block for the verdict.
// Depends on etb_pkg, event_timer_bank and etb_checker.
module tb;
    import etb_pkg::*;

    localparam int         NUM_TIMERS       = 8;
    localparam int         HOLD_CYCLES      = 300;
    localparam int         LIMIT            = 200_000;
    localparam int         RANDOM_PER_PHASE = 95;
    localparam int         DRAIN_CYCLES     = 40;
    localparam logic [2:0] OP_LAST_CODE     = 3'd7;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int errors;
    int pending;
    int checked;
    int fired;
    int cycles = 0;
    int sent;
    bit tx_idle;
    bit rx_idle;
    bit hold_rsp;

    event_timer_bank #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    etb_checker #(
        .NUM_TIMERS(NUM_TIMERS)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked),
        .fired    (fired)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[event_timer_bank] ERROR");
            $finish;
        end
    end

    task automatic send(input req_t item);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req = item;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        sent++;
    endtask

    task automatic issue(input logic [2:0] op, input logic [7:0] id, input logic pf,
                         input logic [15:0] per);
        req_t c;
        c.opcode = op;
        c.timer_id = id;
        c.periodic = pf;
        c.period = per;
        send(c);
    endtask

    function automatic req_t random_command();
        req_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            c.opcode = OP_TICK;
        else if (pick < 50)
            c.opcode = OP_DISPATCH;
        else if (pick < 70)
            c.opcode = OP_START;
        else if (pick < 78)
            c.opcode = OP_STOP;
        else if (pick < 95)
            c.opcode = OP_QUERY;
        else
            c.opcode = 3'($urandom_range(int'(OP_QUERY) + 1, int'(OP_LAST_CODE)));
        if ($urandom_range(0, 99) < 85)
            c.timer_id = 8'($urandom_range(0, NUM_TIMERS - 1));
        else
            c.timer_id = 8'($urandom);
        c.periodic = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80)
            c.period = 16'($urandom_range(1, 8));
        else if (pick < 95)
            c.period = 16'($urandom);
        else
            c.period = '0;
        return c;
    endfunction

    // response side: random stall per transaction, plus one long hold on request
    initial
    begin : rsp_side
        int gap;
        bit held;
        held = 1'b0;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rsp && !held)
            begin
                @(negedge clk);
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                rsp_stall = 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_stall = 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid && !(hold_rsp && !held));
        end
    end

    initial
    begin : stimulus
        req_t c;
        int   ph;
        int   k;
        int   count;
        sent = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_rsp = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue(OP_QUERY, 8'd0, 1'b0, 16'd0);
        issue(OP_DISPATCH, 8'd0, 1'b0, 16'd0);
        issue(OP_START, 8'd0, 1'b0, 16'd1);
        issue(OP_START, 8'd7, 1'b1, 16'd2);
        issue(OP_TICK, 8'd0, 1'b0, 16'd0);
        issue(OP_QUERY, 8'd0, 1'b0, 16'd0);
        issue(OP_DISPATCH, 8'd0, 1'b0, 16'd0);
        issue(OP_TICK, 8'd0, 1'b0, 16'd0);
        issue(OP_QUERY, 8'd7, 1'b0, 16'd0);
        issue(OP_DISPATCH, 8'd0, 1'b0, 16'd0);
        issue(OP_QUERY, 8'd0, 1'b0, 16'd0);
        issue(OP_QUERY, 8'd7, 1'b0, 16'd0);
        issue(OP_STOP, 8'd7, 1'b0, 16'd0);
        issue(OP_QUERY, 8'd7, 1'b0, 16'd0);
        issue(OP_START, 8'hFF, 1'b1, 16'hFFFF);
        issue(OP_STOP, 8'd8, 1'b0, 16'd0);
        issue(OP_QUERY, 8'hFF, 1'b0, 16'd0);
        for (k = int'(OP_QUERY) + 1; k <= int'(OP_LAST_CODE); k++)
            issue(k[2:0], 8'hFF, 1'b1, 16'hFFFF);
        issue(OP_TICK, 8'hFF, 1'b1, 16'hFFFF);
        // every slot due at once: a full dispatch
        for (k = 0; k < NUM_TIMERS; k++)
            issue(OP_START, k[7:0], k[0], 16'd1);
        issue(OP_TICK, 8'd0, 1'b0, 16'd0);
        issue(OP_DISPATCH, 8'd0, 1'b0, 16'd0);
        issue(OP_DISPATCH, 8'd0, 1'b0, 16'd0);

        for (ph = 0; ph < 4; ph++)
        begin
            tx_idle = (ph == 0 || ph == 2);
            rx_idle = (ph == 0 || ph == 3);
            count = 0;
            if (ph == 0)
            begin
                // hold the response side so the block backs up into its input
                hold_rsp = 1'b1;
                for (k = 0; k < 16; k++)
                begin
                    if (k % 4 == 3)
                        issue(OP_DISPATCH, 8'd0, 1'b0, 16'd0);
                    else
                        issue(OP_QUERY, 8'(k % NUM_TIMERS), 1'b0, 16'd0);
                    count++;
                end
            end
            while (count < RANDOM_PER_PHASE)
            begin
                c = random_command();
                send(c);
                if (c.opcode <= OP_QUERY)
                    count++;
            end
        end

        @(negedge clk);
        req_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d command transactions: directed cases and four random phases,", sent);
        $display("one with a long response hold; %0d responses checked, %0d firings",
                 checked, fired);
        if (errors == 0 && pending == 0)
            $display("[event_timer_bank] OK");
        else
            $display("[event_timer_bank] ERROR");
        $finish;
    end

endmodule
